FILE: rtl/pgn_token_scanner_core_defines.svh
// assertion macros for the pgn token scanner
`ifndef PGN_TOKEN_SCANNER_CORE_DEFINES_SVH
`define PGN_TOKEN_SCANNER_CORE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define PGNTS_CHK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pgn token scanner: same-cycle check failed");

// next-cycle implication
`define PGNTS_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pgn token scanner: next-cycle check failed");

`else

`define PGNTS_CHK(lbl, ante, cons)
`define PGNTS_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/pgnts_pkg.sv
package pgnts_pkg;

  localparam int DEPTH_WIDTH_DEF = 16;
  localparam int LINE_WIDTH_DEF  = 24;
  localparam int LINE_SHOW_W     = 24;
  localparam int RBUF_DEPTH      = 7;

  typedef enum logic [1:0] {
    PH_OUT  = 2'd0,
    PH_TAGS = 2'd1,
    PH_GAME = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    M_IDLE = 4'd0,
    M_SKIP = 4'd1,
    M_ESC  = 4'd2,
    M_TAG  = 4'd3,
    M_COMM = 4'd4,
    M_LINE = 4'd5,
    M_NAG  = 4'd6,
    M_NUM  = 4'd7,
    M_MOVE = 4'd8
  } mode_t;

  typedef enum logic [1:0] {
    CL_NONE    = 2'd0,
    CL_PAREN   = 2'd1,
    CL_BRACE   = 2'd2,
    CL_NEWLINE = 2'd3
  } closer_t;

  typedef enum logic [2:0] {
    TT_NONE    = 3'd0,
    TT_TAG     = 3'd1,
    TT_COMMENT = 3'd2,
    TT_LINE    = 3'd3,
    TT_NAG     = 3'd4,
    TT_RESULT  = 3'd5,
    TT_NUMBER  = 3'd6,
    TT_MOVE    = 3'd7
  } tok_t;

  typedef enum logic [1:0] {
    TP_NONE  = 2'd0,
    TP_NAME  = 2'd1,
    TP_VALUE = 2'd2
  } tag_part_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [23:0] RES_WIN  = "1-0";
  localparam logic [23:0] RES_LOSS = "0-1";
  localparam logic [55:0] RES_DRAW = "1/2-1/2";

  typedef logic [RBUF_DEPTH-1:0][7:0] rbuf_t;

  typedef struct packed {
    logic                   text_valid;
    logic [7:0]             text_byte;
    logic [1:0]             tag_part;
    logic                   token_done;
    logic [2:0]             token_type;
    logic                   game_end;
    logic [LINE_SHOW_W-1:0] line_count;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
  endfunction

  function automatic logic is_tag_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic logic is_result(input rbuf_t b, input logic [3:0] len);
    logic [23:0] head;
    logic [55:0] full;
    head = {b[0], b[1], b[2]};
    full = {b[0], b[1], b[2], b[3], b[4], b[5], b[6]};
    return ((len == 4'd3) && ((head == RES_WIN) || (head == RES_LOSS))) ||
           ((len == 4'd7) && (full == RES_DRAW));
  endfunction

endpackage

FILE: rtl/pgnts_in_if.sv
interface pgnts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

FILE: rtl/pgnts_out_if.sv
interface pgnts_out_if;
  logic        valid;
  logic        ready;
  logic        text_valid;
  logic [7:0]  text_byte;
  logic [1:0]  tag_part;
  logic        token_done;
  logic [2:0]  token_type;
  logic        game_end;
  logic [23:0] line_count;

  modport source (
    output valid, output text_valid, output text_byte, output tag_part,
    output token_done, output token_type, output game_end, output line_count,
    input ready
  );
  modport sink (
    input valid, input text_valid, input text_byte, input tag_part,
    input token_done, input token_type, input game_end, input line_count,
    output ready
  );
endinterface

FILE: rtl/pgnts_scan_fsm.sv
`include "pgn_token_scanner_core_defines.svh"

module pgnts_scan_fsm #(
  parameter int DEPTH_WIDTH = pgnts_pkg::DEPTH_WIDTH_DEF,
  parameter int LINE_WIDTH  = pgnts_pkg::LINE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          data_byte,
  input  logic                end_of_data,
  output pgnts_pkg::result_t  res
);

  pgnts_pkg::phase_t      phase_r, phase_nxt;
  pgnts_pkg::mode_t       mode_r, mode_nxt;
  pgnts_pkg::closer_t     closer_r, closer_nxt;
  logic [DEPTH_WIDTH-1:0] depth_r, depth_nxt;
  logic [2:0]             tag_step_r, tag_step_nxt;
  logic                   in_quotes_r, in_quotes_nxt;
  logic                   nonempty_r, nonempty_nxt;
  logic [3:0]             rlen_r, rlen_nxt;
  logic [LINE_WIDTH-1:0]  line_r, line_nxt;
  pgnts_pkg::rbuf_t       rbuf_r;
  logic                   rbuf_we;
  logic [2:0]             rbuf_addr;

  logic                   is_end;
  logic                   ws;
  logic                   tsp;
  logic                   digit;
  logic                   num_res;
  logic [7:0]             skip_close_ch;
  logic                   skip_open_hit;
  logic                   comm_open_hit;
  logic                   comm_close_hit;
  logic [DEPTH_WIDTH-1:0] depth_inc;
  logic [DEPTH_WIDTH-1:0] depth_dec;
  logic [LINE_WIDTH-1:0]  line_inc;
  logic [LINE_WIDTH-1:0]  lc_raw;
  logic [pgnts_pkg::LINE_SHOW_W-1:0] lc_show;

  assign is_end  = end_of_data || (data_byte == pgnts_pkg::CH_NUL);
  assign ws      = pgnts_pkg::is_ws(data_byte);
  assign tsp     = pgnts_pkg::is_tag_space(data_byte);
  assign digit   = (data_byte >= pgnts_pkg::CH_ZERO) && (data_byte <= pgnts_pkg::CH_NINE);
  assign num_res = pgnts_pkg::is_result(rbuf_r, rlen_r);

  always_comb begin
    unique case (closer_r)
      pgnts_pkg::CL_PAREN: skip_close_ch = pgnts_pkg::CH_RPAREN;
      pgnts_pkg::CL_BRACE: skip_close_ch = pgnts_pkg::CH_RBRACE;
      default:             skip_close_ch = pgnts_pkg::CH_NL;
    endcase
  end

  assign skip_open_hit =
    ((closer_r == pgnts_pkg::CL_PAREN) && (data_byte == pgnts_pkg::CH_LPAREN)) ||
    ((closer_r == pgnts_pkg::CL_BRACE) && (data_byte == pgnts_pkg::CH_LBRACE));
  assign comm_open_hit = (closer_r == pgnts_pkg::CL_PAREN) ?
    (data_byte == pgnts_pkg::CH_LPAREN) : (data_byte == pgnts_pkg::CH_LBRACE);
  assign comm_close_hit = (closer_r == pgnts_pkg::CL_PAREN) ?
    (data_byte == pgnts_pkg::CH_RPAREN) : (data_byte == pgnts_pkg::CH_RBRACE);

  assign depth_inc = (depth_r != '1) ? depth_r + DEPTH_WIDTH'(1) : depth_r;
  assign depth_dec = (depth_r != '0) ? depth_r - DEPTH_WIDTH'(1) : depth_r;
  assign line_inc  = ((data_byte == pgnts_pkg::CH_NL) && (line_r != '1)) ?
                     line_r + LINE_WIDTH'(1) : line_r;

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    mode_nxt      = mode_r;
    closer_nxt    = closer_r;
    depth_nxt     = depth_r;
    tag_step_nxt  = tag_step_r;
    in_quotes_nxt = in_quotes_r;
    nonempty_nxt  = nonempty_r;
    rlen_nxt      = rlen_r;
    line_nxt      = line_r;
    rbuf_we       = 1'b0;
    rbuf_addr     = rlen_r[2:0];
    if (is_end) begin
      phase_nxt     = pgnts_pkg::PH_OUT;
      mode_nxt      = pgnts_pkg::M_IDLE;
      closer_nxt    = pgnts_pkg::CL_NONE;
      depth_nxt     = '0;
      tag_step_nxt  = '0;
      in_quotes_nxt = 1'b0;
      nonempty_nxt  = 1'b0;
      rlen_nxt      = '0;
      line_nxt      = LINE_WIDTH'(1);
    end else begin
      line_nxt = line_inc;
      case (mode_r)
        pgnts_pkg::M_IDLE: begin
          if (phase_r == pgnts_pkg::PH_OUT) begin
            priority if (data_byte == pgnts_pkg::CH_LBRACK) begin
              phase_nxt     = pgnts_pkg::PH_TAGS;
              mode_nxt      = pgnts_pkg::M_TAG;
              tag_step_nxt  = '0;
              in_quotes_nxt = 1'b0;
            end else if (data_byte == pgnts_pkg::CH_LPAREN) begin
              closer_nxt = pgnts_pkg::CL_PAREN;
              depth_nxt  = DEPTH_WIDTH'(1);
              mode_nxt   = pgnts_pkg::M_SKIP;
            end else if (data_byte == pgnts_pkg::CH_LBRACE) begin
              closer_nxt = pgnts_pkg::CL_BRACE;
              depth_nxt  = DEPTH_WIDTH'(1);
              mode_nxt   = pgnts_pkg::M_SKIP;
            end else if ((data_byte == pgnts_pkg::CH_SEMI) ||
                         (data_byte == pgnts_pkg::CH_PCT)) begin
              closer_nxt = pgnts_pkg::CL_NEWLINE;
              depth_nxt  = DEPTH_WIDTH'(1);
              mode_nxt   = pgnts_pkg::M_SKIP;
            end else begin
            end
          end else begin
            priority if (ws || (data_byte == pgnts_pkg::CH_DOT)) begin
            end else if (data_byte == pgnts_pkg::CH_PCT) begin
              mode_nxt = pgnts_pkg::M_ESC;
            end else if (data_byte == pgnts_pkg::CH_LBRACK) begin
              phase_nxt     = pgnts_pkg::PH_TAGS;
              mode_nxt      = pgnts_pkg::M_TAG;
              tag_step_nxt  = '0;
              in_quotes_nxt = 1'b0;
            end else if ((data_byte == pgnts_pkg::CH_LPAREN) ||
                         (data_byte == pgnts_pkg::CH_LBRACE)) begin
              closer_nxt   = (data_byte == pgnts_pkg::CH_LPAREN) ?
                             pgnts_pkg::CL_PAREN : pgnts_pkg::CL_BRACE;
              depth_nxt    = DEPTH_WIDTH'(1);
              nonempty_nxt = 1'b0;
              mode_nxt     = pgnts_pkg::M_COMM;
            end else if (data_byte == pgnts_pkg::CH_SEMI) begin
              mode_nxt = pgnts_pkg::M_LINE;
            end else if (data_byte == pgnts_pkg::CH_DOLLAR) begin
              mode_nxt = pgnts_pkg::M_NAG;
            end else if (data_byte == pgnts_pkg::CH_STAR) begin
              phase_nxt = pgnts_pkg::PH_OUT;
            end else if (digit) begin
              rbuf_we   = 1'b1;
              rbuf_addr = 3'd0;
              rlen_nxt  = 4'd1;
              mode_nxt  = pgnts_pkg::M_NUM;
            end else begin
              phase_nxt = pgnts_pkg::PH_GAME;
              mode_nxt  = pgnts_pkg::M_MOVE;
            end
          end
        end
        pgnts_pkg::M_SKIP: begin
          if (data_byte == skip_close_ch) begin
            depth_nxt = depth_dec;
            if (depth_dec == '0) begin
              mode_nxt   = pgnts_pkg::M_IDLE;
              closer_nxt = pgnts_pkg::CL_NONE;
            end
          end else if (skip_open_hit) begin
            depth_nxt = depth_inc;
          end
        end
        pgnts_pkg::M_ESC: begin
          if ((data_byte == pgnts_pkg::CH_NL) || (data_byte == pgnts_pkg::CH_CR)) begin
            mode_nxt = pgnts_pkg::M_IDLE;
          end
        end
        pgnts_pkg::M_TAG: begin
          if ((!in_quotes_r && (data_byte == pgnts_pkg::CH_RBRACK)) ||
              (data_byte == pgnts_pkg::CH_NL) || (data_byte == pgnts_pkg::CH_CR)) begin
            mode_nxt      = pgnts_pkg::M_IDLE;
            tag_step_nxt  = '0;
            in_quotes_nxt = 1'b0;
          end else begin
            case (tag_step_r)
              3'd0: if (!tsp) tag_step_nxt = 3'd1;
              3'd1: if (tsp) tag_step_nxt = 3'd2;
              3'd2: begin
                if (!tsp) begin
                  tag_step_nxt = 3'd3;
                  if (data_byte == pgnts_pkg::CH_QUOTE) in_quotes_nxt = 1'b1;
                end
              end
              3'd3: begin
                if (in_quotes_r && (data_byte == pgnts_pkg::CH_QUOTE)) begin
                  in_quotes_nxt = 1'b0;
                  tag_step_nxt  = 3'd4;
                end
              end
              default: begin
              end
            endcase
          end
        end
        pgnts_pkg::M_COMM: begin
          if (comm_open_hit) begin
            depth_nxt = depth_inc;
          end else if (comm_close_hit) begin
            depth_nxt = depth_dec;
          end
          if (comm_close_hit && (depth_dec == '0)) begin
            mode_nxt     = pgnts_pkg::M_IDLE;
            closer_nxt   = pgnts_pkg::CL_NONE;
            nonempty_nxt = 1'b0;
          end else if ((data_byte != pgnts_pkg::CH_NL) || nonempty_r) begin
            nonempty_nxt = 1'b1;
          end
        end
        pgnts_pkg::M_LINE: begin
          if ((data_byte == pgnts_pkg::CH_NL) || (data_byte == pgnts_pkg::CH_CR)) begin
            mode_nxt = pgnts_pkg::M_IDLE;
          end
        end
        pgnts_pkg::M_NAG, pgnts_pkg::M_MOVE: begin
          if (ws) mode_nxt = pgnts_pkg::M_IDLE;
        end
        pgnts_pkg::M_NUM: begin
          if (ws || (data_byte == pgnts_pkg::CH_DOT)) begin
            phase_nxt = num_res ? pgnts_pkg::PH_OUT : pgnts_pkg::PH_GAME;
            mode_nxt  = pgnts_pkg::M_IDLE;
            rlen_nxt  = '0;
          end else if (rlen_r < 4'd7) begin
            rbuf_we  = 1'b1;
            rlen_nxt = rlen_r + 4'd1;
          end else begin
            rlen_nxt = 4'd8;
          end
        end
        default: mode_nxt = pgnts_pkg::M_IDLE;
      endcase
    end
  end

  // outputs
  always_comb begin
    res            = '0;
    res.line_count = lc_show;
    if (is_end) begin
      res.token_done = 1'b1;
      case (mode_r)
        pgnts_pkg::M_TAG:  res.token_type = pgnts_pkg::TT_TAG;
        pgnts_pkg::M_COMM: res.token_type = pgnts_pkg::TT_COMMENT;
        pgnts_pkg::M_LINE: res.token_type = pgnts_pkg::TT_LINE;
        pgnts_pkg::M_NAG:  res.token_type = pgnts_pkg::TT_NAG;
        pgnts_pkg::M_MOVE: res.token_type = pgnts_pkg::TT_MOVE;
        pgnts_pkg::M_NUM: begin
          res.token_type = num_res ? pgnts_pkg::TT_RESULT : pgnts_pkg::TT_NUMBER;
          res.game_end   = num_res;
        end
        default: res.token_done = 1'b0;
      endcase
    end else begin
      case (mode_r)
        pgnts_pkg::M_IDLE: begin
          if (phase_r != pgnts_pkg::PH_OUT) begin
            priority if (ws || (data_byte == pgnts_pkg::CH_DOT) ||
                         (data_byte == pgnts_pkg::CH_PCT) ||
                         (data_byte == pgnts_pkg::CH_LPAREN) ||
                         (data_byte == pgnts_pkg::CH_LBRACE) ||
                         (data_byte == pgnts_pkg::CH_SEMI) ||
                         (data_byte == pgnts_pkg::CH_DOLLAR)) begin
            end else if (data_byte == pgnts_pkg::CH_LBRACK) begin
              res.game_end = (phase_r != pgnts_pkg::PH_TAGS);
            end else if (data_byte == pgnts_pkg::CH_STAR) begin
              res.text_valid = 1'b1;
              res.token_done = 1'b1;
              res.token_type = pgnts_pkg::TT_RESULT;
              res.game_end   = 1'b1;
            end else begin
              res.text_valid = 1'b1;
            end
          end
        end
        pgnts_pkg::M_TAG: begin
          if ((!in_quotes_r && (data_byte == pgnts_pkg::CH_RBRACK)) ||
              (data_byte == pgnts_pkg::CH_NL) || (data_byte == pgnts_pkg::CH_CR)) begin
            res.token_done = 1'b1;
            res.token_type = pgnts_pkg::TT_TAG;
          end else begin
            res.text_valid = 1'b1;
            case (tag_step_r)
              3'd0, 3'd1: if (!tsp) res.tag_part = pgnts_pkg::TP_NAME;
              3'd2: begin
                if (!tsp && (data_byte != pgnts_pkg::CH_QUOTE)) begin
                  res.tag_part = pgnts_pkg::TP_VALUE;
                end
              end
              3'd3: begin
                if (in_quotes_r ? (data_byte != pgnts_pkg::CH_QUOTE) : !tsp) begin
                  res.tag_part = pgnts_pkg::TP_VALUE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        pgnts_pkg::M_COMM: begin
          if (comm_close_hit && (depth_dec == '0)) begin
            res.token_done = 1'b1;
            res.token_type = pgnts_pkg::TT_COMMENT;
          end else begin
            res.text_valid = (data_byte != pgnts_pkg::CH_NL) || nonempty_r;
          end
        end
        pgnts_pkg::M_LINE: begin
          if ((data_byte == pgnts_pkg::CH_NL) || (data_byte == pgnts_pkg::CH_CR)) begin
            res.token_done = 1'b1;
            res.token_type = pgnts_pkg::TT_LINE;
          end else begin
            res.text_valid = 1'b1;
          end
        end
        pgnts_pkg::M_NAG: begin
          res.text_valid = !ws;
          res.token_done = ws;
          res.token_type = ws ? pgnts_pkg::TT_NAG : pgnts_pkg::TT_NONE;
        end
        pgnts_pkg::M_MOVE: begin
          res.text_valid = !ws;
          res.token_done = ws;
          res.token_type = ws ? pgnts_pkg::TT_MOVE : pgnts_pkg::TT_NONE;
        end
        pgnts_pkg::M_NUM: begin
          if (ws || (data_byte == pgnts_pkg::CH_DOT)) begin
            res.token_done = 1'b1;
            res.token_type = num_res ? pgnts_pkg::TT_RESULT : pgnts_pkg::TT_NUMBER;
            res.game_end   = num_res;
          end else begin
            res.text_valid = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    res.text_byte = res.text_valid ? data_byte : 8'h00;
  end

  assign lc_raw = is_end ? line_r : line_inc;

  generate
    if (LINE_WIDTH > pgnts_pkg::LINE_SHOW_W) begin : g_lc_sat
      assign lc_show = (|lc_raw[LINE_WIDTH-1:pgnts_pkg::LINE_SHOW_W]) ?
                       '1 : lc_raw[pgnts_pkg::LINE_SHOW_W-1:0];
    end else begin : g_lc_ext
      assign lc_show = pgnts_pkg::LINE_SHOW_W'(lc_raw);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= pgnts_pkg::PH_OUT;
      mode_r      <= pgnts_pkg::M_IDLE;
      closer_r    <= pgnts_pkg::CL_NONE;
      depth_r     <= '0;
      tag_step_r  <= '0;
      in_quotes_r <= 1'b0;
      nonempty_r  <= 1'b0;
      rlen_r      <= '0;
      line_r      <= LINE_WIDTH'(1);
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      mode_r      <= mode_nxt;
      closer_r    <= closer_nxt;
      depth_r     <= depth_nxt;
      tag_step_r  <= tag_step_nxt;
      in_quotes_r <= in_quotes_nxt;
      nonempty_r  <= nonempty_nxt;
      rlen_r      <= rlen_nxt;
      line_r      <= line_nxt;
    end
  end

  // number buffer, only entries below the fill length are ever compared
  always_ff @(posedge clk) begin
    if (step_en && !is_end && rbuf_we) begin
      rbuf_r[rbuf_addr] <= data_byte;
    end
  end

  `PGNTS_CHK(a_nest_nonzero, (mode_r == pgnts_pkg::M_SKIP) || (mode_r == pgnts_pkg::M_COMM), depth_r != '0)
  `PGNTS_CHK(a_line_nonzero, 1'b1, line_r != '0)
  `PGNTS_CHK(a_tag_part_src, res.tag_part != pgnts_pkg::TP_NONE, res.text_valid && (mode_r == pgnts_pkg::M_TAG))
  `PGNTS_CHK(a_game_end_type, res.game_end && res.token_done, res.token_type == pgnts_pkg::TT_RESULT)
  `PGNTS_NEXT(a_end_clears, step_en && is_end, (mode_r == pgnts_pkg::M_IDLE) && (phase_r == pgnts_pkg::PH_OUT) && (line_r == LINE_WIDTH'(1)))

endmodule

FILE: rtl/pgn_token_scanner_core.sv
// pgn token scanner
// in_chan carries one text byte per transfer (data_byte, end_of_data);
// out_chan returns exactly one result per input transfer, in order, with
// token text bytes, tag name/value marks, token completion and type,
// game end and the current line number.
// the result of a byte is held in an output register and is on out_chan in
// the cycle after its transfer. throughput: one byte per cycle while not
// stalled; state updates use a single level of decode logic per byte.
// in_chan.ready is high while the output register is empty or being taken
// in the same cycle, so a stalled receiver holds one result and stops input
// only while that result waits.
// a NUL byte or end_of_data closes the stream: open tokens complete and the
// scanner returns to its reset state for the next stream.
// reset (rst_n low, synchronous) empties the output register, puts the
// scanner out of game and sets the line counter to one.
`include "pgn_token_scanner_core_defines.svh"

module pgn_token_scanner_core #(
  parameter int DEPTH_WIDTH = pgnts_pkg::DEPTH_WIDTH_DEF,
  parameter int LINE_WIDTH  = pgnts_pkg::LINE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pgnts_in_if.sink    in_chan,
  pgnts_out_if.source out_chan
);

  pgnts_pkg::result_t step_res;
  pgnts_pkg::result_t out_res_r;
  logic               out_valid_r;
  logic               in_fire;
  logic               out_ready;

  assign out_ready     = out_chan.ready;
  assign in_chan.ready = !out_valid_r || out_ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  pgnts_scan_fsm #(
    .DEPTH_WIDTH (DEPTH_WIDTH),
    .LINE_WIDTH  (LINE_WIDTH)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (in_fire),
    .data_byte   (in_chan.data_byte),
    .end_of_data (in_chan.end_of_data),
    .res         (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register, loaded on every input transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res_r <= step_res;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.text_valid = out_res_r.text_valid;
  assign out_chan.text_byte  = out_res_r.text_byte;
  assign out_chan.tag_part   = out_res_r.tag_part;
  assign out_chan.token_done = out_res_r.token_done;
  assign out_chan.token_type = out_res_r.token_type;
  assign out_chan.game_end   = out_res_r.game_end;
  assign out_chan.line_count = out_res_r.line_count;

  `PGNTS_NEXT(a_fire_fills, in_fire, out_valid_r)
  `PGNTS_NEXT(a_stall_holds, out_valid_r && !out_ready, out_valid_r)
  `PGNTS_CHK(a_no_fire_full, out_valid_r && !out_ready, !in_fire)

endmodule
